@@ src/fmac_pkg.sv @@
// Shared types and constants for the first-match ACL classifier.
// No dependencies; used by every module of the block.
`default_nettype none
package fmac_pkg;

  localparam int MaxRulesDefault = 64;
  localparam int QueueDepth      = 2;

  // Item kinds.
  localparam logic [1:0] KIND_APPEND   = 2'd0;
  localparam logic [1:0] KIND_DELETE   = 2'd1;
  localparam logic [1:0] KIND_CLASSIFY = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        is_ipv6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        has_prefix;
    logic [7:0]  prefix_bits;
    logic [15:0] port_value;
    logic        port_wild;
    logic        allow_flag;
    logic [5:0]  rule_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       allowed;
    logic       matched;
    logic [5:0] match_index;
    logic [6:0] rule_total;
  } out_item_t;

  // Stored rule: address plus attributes.
  typedef struct packed {
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
    logic        allow;
    logic        is_ipv6;
    logic        has_prefix;
    logic [7:0]  prefix_bits;
    logic [15:0] port;
    logic        port_wild;
  } rule_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } engine_state_t;

  // Top n bits set in a 64-bit word, n saturating at 64.
  function automatic logic [63:0] top_mask(input logic [7:0] n);
    logic [63:0] m;
    m = '0;
    if (n >= 8'd64) begin
      m = '1;
    end else if (n != 8'd0) begin
      m = ~(64'hFFFF_FFFF_FFFF_FFFF >> n[5:0]);
    end
    return m;
  endfunction

  // Match of one stored rule against a packet.
  function automatic logic rule_hit(input rule_t r, input in_item_t p);
    logic [7:0]  len;
    logic [63:0] mh;
    logic [63:0] ml;
    logic [31:0] m4;
    logic        hit;
    hit = 1'b0;
    if (r.is_ipv6 == p.is_ipv6 && (r.port_wild || r.port == p.port_value)) begin
      if (p.is_ipv6) begin
        len = (!r.has_prefix || r.prefix_bits > 8'd128) ? 8'd128 : r.prefix_bits;
        mh  = top_mask(len);
        ml  = top_mask((len > 8'd64) ? len - 8'd64 : 8'd0);
        hit = (((p.addr_high ^ r.addr_upper) & mh) == '0) &&
              (((p.addr_low ^ r.addr_lower) & ml) == '0);
      end else begin
        len = (!r.has_prefix || r.prefix_bits > 8'd32) ? 8'd32 : r.prefix_bits;
        mh  = top_mask(len);
        m4  = mh[63:32];
        hit = ((p.addr_low[31:0] ^ r.addr_lower[31:0]) & m4) == '0;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

@@ src/fmac_queue.sv @@
// Small FIFO that decouples the front end from the rule engine.
// Depends on fmac_pkg for the transaction type.
`default_nettype none
module fmac_queue
  import fmac_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_valid,
  output      logic     wr_ready,
  input  wire in_item_t wr_data,
  output      logic     rd_valid,
  input  wire logic     rd_ready,
  output      in_item_t rd_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  in_item_t          slot_r [Depth];
  logic [AW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r;
  logic              push, pop;

  assign wr_ready = (cnt_r != CW'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Storage writes carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end
endmodule
`default_nettype wire

@@ src/fmac_engine.sv @@
// Rule engine: holds the rule memory and runs append, delete and classify.
// Depends on fmac_pkg; a scan or shift reads one rule per cycle.
`default_nettype none
module fmac_engine
  import fmac_pkg::*;
#(
  parameter int MaxRules = MaxRulesDefault
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cmd_valid,
  output      logic      cmd_ready,
  input  wire in_item_t  cmd_data,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);
  localparam int IW = (MaxRules > 1) ? $clog2(MaxRules) : 1;
  localparam int CW = $clog2(MaxRules + 1);

  rule_t          mem [MaxRules];
  rule_t          rd_q;
  logic [IW-1:0]  rd_addr;
  logic           rd_en;
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  rule_t          wr_rule;

  engine_state_t  state_r, state_nxt;
  in_item_t       cur_r, cur_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  pos_r, pos_nxt;
  logic           rd_ok_r, rd_ok_nxt;
  logic           ov_r, ov_nxt;
  out_item_t      res_r, res_nxt;
  logic           take;

  // Rule memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rule;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign cmd_ready = (state_r == ST_IDLE) && !ov_r;
  assign take      = cmd_valid && cmd_ready;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  // Sequencer for the three kinds of transaction.
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    rd_ok_nxt = 1'b0;
    ov_nxt    = ov_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = pos_r[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = count_r[IW-1:0];
    wr_rule   = '{addr_upper: cmd_data.addr_high, addr_lower: cmd_data.addr_low,
                  allow: cmd_data.allow_flag, is_ipv6: cmd_data.is_ipv6,
                  has_prefix: cmd_data.has_prefix, prefix_bits: cmd_data.prefix_bits,
                  port: cmd_data.port_value, port_wild: cmd_data.port_wild};
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          cur_nxt = cmd_data;
          res_nxt = '{status: STATUS_OK, allowed: 1'b0, matched: 1'b0,
                      match_index: 6'd0, rule_total: 7'(count_r)};
          case (cmd_data.kind)
            KIND_APPEND: begin
              if (count_r >= CW'(MaxRules)) begin
                res_nxt.status = STATUS_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                res_nxt.rule_total = 7'(count_r + 1'b1);
              end
              ov_nxt = 1'b1;
            end
            KIND_DELETE: begin
              if (CW'(cmd_data.rule_index) >= count_r) begin
                res_nxt.status = STATUS_BAD_INDEX;
                ov_nxt = 1'b1;
              end else begin
                // Read the rule after the hole, then shift down.
                pos_nxt   = CW'(cmd_data.rule_index) + 1'b1;
                rd_addr   = IW'(CW'(cmd_data.rule_index) + 1'b1);
                rd_en     = (CW'(cmd_data.rule_index) + 1'b1) < count_r;
                rd_ok_nxt = rd_en;
                state_nxt = ST_SHIFT;
              end
            end
            KIND_CLASSIFY: begin
              pos_nxt   = '0;
              rd_addr   = '0;
              rd_en     = (count_r != '0);
              rd_ok_nxt = rd_en;
              state_nxt = ST_SCAN;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_ok_r && rule_hit(rd_q, cur_r)) begin
          res_nxt.matched     = 1'b1;
          res_nxt.allowed     = rd_q.allow;
          res_nxt.match_index = 6'(pos_r);
          state_nxt = ST_DONE;
        end else if (!rd_ok_r || pos_r + 1'b1 >= count_r) begin
          state_nxt = ST_DONE;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          rd_addr   = IW'(pos_r + 1'b1);
          rd_en     = 1'b1;
          rd_ok_nxt = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (rd_ok_r) begin
          wr_en   = 1'b1;
          wr_addr = IW'(pos_r - 1'b1);
          wr_rule = rd_q;
        end
        if (rd_ok_r && pos_r + 1'b1 < count_r) begin
          pos_nxt   = pos_r + 1'b1;
          rd_addr   = IW'(pos_r + 1'b1);
          rd_en     = 1'b1;
          rd_ok_nxt = 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
          res_nxt.rule_total = 7'(count_r - 1'b1);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    pos_r <= pos_nxt;
    res_r <= res_nxt;
  end
endmodule
`default_nettype wire

@@ src/first_match_acl_classifier.sv @@
// First-match ACL classifier: a small input queue feeding the rule engine.
// Depends on fmac_pkg, fmac_queue and fmac_engine.
//
// Transactions are appends, deletes and packet lookups against an ordered
// table of up to MaxRules rules kept in a single-port-read rule memory. A
// delete at index i moves the later rules up one per cycle, and a lookup
// scans the memory one rule per cycle until the first hit or the end of
// the table. A two-entry queue in front takes new transactions while the
// engine is busy or its result waits to be taken.
`default_nettype none
module first_match_acl_classifier
  import fmac_pkg::*;
#(
  parameter int MaxRules = MaxRulesDefault
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);
  logic     q_valid, q_ready;
  in_item_t q_data;

  fmac_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  fmac_engine #(.MaxRules(MaxRules)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // A result never reports more rules than the table holds.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.rule_total <= 7'(MaxRules)))
    else $error("rule total above table size");

  // A match is only reported for a lookup with a real index.
  a_match_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.matched) |-> (7'(out_data.match_index) < out_data.rule_total))
    else $error("match index beyond table");

  // A stalled result stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
endmodule
`default_nettype wire
